// ===== hdl/region_color_statistics_macros.svh =====
// Assertion macros used by the region colour statistics controller.
`ifndef REGION_COLOR_STATISTICS_MACROS_SVH
`define REGION_COLOR_STATISTICS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rcs_pkg.sv =====
// Types, constants and helpers for the region colour statistics block.
package rcs_pkg;

    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_COUNT_BITS = 24;
    localparam int DIM_W          = 13;
    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int Q_W            = 17;
    localparam int FRAC_W         = 16;
    localparam int NUM_JOBS       = 9;

    localparam logic [DIM_W-1:0] DEF_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] DEF_HEIGHT = 13'd480;
    localparam logic [Q_W-1:0]   CAP_FULL   = 17'd65536;
    localparam logic [Q_W-1:0]   CAP_FRAC   = 17'd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_ACC,
        S_MLOAD,
        S_MRUN,
        S_DLOAD,
        S_DRUN,
        S_STORE,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        JOB_AREA,
        JOB_MEAN_X,
        JOB_MEAN_Y,
        JOB_MEAN_L,
        JOB_MEAN_A,
        JOB_MEAN_B,
        JOB_VAR_L,
        JOB_VAR_A,
        JOB_VAR_B
    } job_t;

    typedef struct packed {
        logic       acc;
        logic       mul_load;
        logic       mul_step;
        logic       capture;
        logic       div_load;
        logic       div_step;
        logic       store;
        logic       emit;
        job_t       job;
        logic [1:0] mstep;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } status_t;

    // Number of products a job needs before its division.
    function automatic logic [1:0] mul_count(job_t job);
        logic [1:0] n;
        unique case (job)
            JOB_AREA, JOB_MEAN_X, JOB_MEAN_Y: n = 2'd1;
            JOB_MEAN_L, JOB_MEAN_A, JOB_MEAN_B: n = 2'd0;
            default: n = 2'd3;
        endcase
        return n;
    endfunction

    // Colour channel a job works on.
    function automatic logic [1:0] chan_sel(job_t job);
        logic [1:0] c;
        unique case (job)
            JOB_MEAN_A, JOB_VAR_A: c = 2'd1;
            JOB_MEAN_B, JOB_VAR_B: c = 2'd2;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/rcs_pixel_if.sv =====
// Pixel input channel.
interface rcs_pixel_if #(
    parameter int COORD_BITS = rcs_pkg::DEF_COORD_BITS
);
    logic                        valid;
    logic                        ready;
    logic [COORD_BITS-1:0]       x_coord;
    logic [COORD_BITS-1:0]       y_coord;
    logic [rcs_pkg::CHAN_W-1:0]  chan_l;
    logic [rcs_pkg::CHAN_W-1:0]  chan_a;
    logic [rcs_pkg::CHAN_W-1:0]  chan_b;
    logic                        last_pixel;

    modport source (output valid, x_coord, y_coord, chan_l, chan_a, chan_b, last_pixel,
                    input ready);
    modport sink (input valid, x_coord, y_coord, chan_l, chan_a, chan_b, last_pixel,
                  output ready);
endinterface

// ===== hdl/rcs_desc_if.sv =====
// Region descriptor output channel.
interface rcs_desc_if;
    logic                        valid;
    logic                        ready;
    logic [rcs_pkg::Q_W-1:0]     area_fraction;
    logic [rcs_pkg::FRAC_W-1:0]  mean_x_norm;
    logic [rcs_pkg::FRAC_W-1:0]  mean_y_norm;
    logic [rcs_pkg::FRAC_W-1:0]  mean_l;
    logic [rcs_pkg::FRAC_W-1:0]  mean_a;
    logic [rcs_pkg::FRAC_W-1:0]  mean_b;
    logic [rcs_pkg::Q_W-1:0]     inv_var_l;
    logic [rcs_pkg::Q_W-1:0]     inv_var_a;
    logic [rcs_pkg::Q_W-1:0]     inv_var_b;

    modport source (output valid, area_fraction, mean_x_norm, mean_y_norm, mean_l, mean_a,
                    mean_b, inv_var_l, inv_var_a, inv_var_b, input ready);
    modport sink (input valid, area_fraction, mean_x_norm, mean_y_norm, mean_l, mean_a,
                  mean_b, inv_var_l, inv_var_a, inv_var_b, output ready);
endinterface

// ===== hdl/rcs_cfg_if.sv =====
// Configuration write channel.
interface rcs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rcs_pkg::CFG_IDX_W-1:0]  index;
    logic [rcs_pkg::DIM_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/rcs_datapath.sv =====
// Accumulators, shift-add multiplier, restoring divider and result registers.
module rcs_datapath #(
    parameter int COORD_BITS = rcs_pkg::DEF_COORD_BITS,
    parameter int COUNT_BITS = rcs_pkg::DEF_COUNT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rcs_pkg::cmd_t                   cmd,
    output rcs_pkg::status_t                status,
    input  logic                            cfg_valid,
    input  logic [rcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcs_pkg::DIM_W-1:0]       cfg_data,
    input  logic [COORD_BITS-1:0]           x_coord,
    input  logic [COORD_BITS-1:0]           y_coord,
    input  logic [rcs_pkg::CHAN_W-1:0]      chan_l,
    input  logic [rcs_pkg::CHAN_W-1:0]      chan_a,
    input  logic [rcs_pkg::CHAN_W-1:0]      chan_b,
    output logic [rcs_pkg::Q_W-1:0]         area_fraction,
    output logic [rcs_pkg::FRAC_W-1:0]      mean_x_norm,
    output logic [rcs_pkg::FRAC_W-1:0]      mean_y_norm,
    output logic [rcs_pkg::FRAC_W-1:0]      mean_l,
    output logic [rcs_pkg::FRAC_W-1:0]      mean_a,
    output logic [rcs_pkg::FRAC_W-1:0]      mean_b,
    output logic [rcs_pkg::Q_W-1:0]         inv_var_l,
    output logic [rcs_pkg::Q_W-1:0]         inv_var_a,
    output logic [rcs_pkg::Q_W-1:0]         inv_var_b
);
    localparam int CNT_W  = COUNT_BITS + 1;
    localparam int SCOL_W = COUNT_BITS + COORD_BITS;
    localparam int SCH_W  = COUNT_BITS + rcs_pkg::CHAN_W;
    localparam int SSQ_W  = COUNT_BITS + 2 * rcs_pkg::CHAN_W;
    localparam int MOP_W  = SSQ_W;
    localparam int PRD_W  = 2 * MOP_W;
    localparam int D_W    = (2 * CNT_W + 16 > SCOL_W + 16) ? 2 * CNT_W + 16 : SCOL_W + 16;
    localparam int MCNT_W = $clog2(MOP_W + 1);
    localparam int DCNT_W = $clog2(D_W + 1);
    localparam int Q_W    = rcs_pkg::Q_W;
    localparam int F_W    = rcs_pkg::FRAC_W;

    logic [rcs_pkg::DIM_W-1:0]  width_reg, height_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [SCOL_W-1:0]          scol_reg, srow_reg;
    logic [SCH_W-1:0]           sch_reg [rcs_pkg::NUM_CHAN];
    logic [SSQ_W-1:0]           ssq_reg [rcs_pkg::NUM_CHAN];
    logic [rcs_pkg::CHAN_W-1:0] pix_chan [rcs_pkg::NUM_CHAN];

    logic [PRD_W-1:0]  mcand_reg, prod_reg;
    logic [MOP_W-1:0]  mplier_reg;
    logic [MCNT_W-1:0] mcnt_reg;
    logic [D_W-1:0]    cap_reg [3];

    logic [D_W-1:0]    num_reg, den_reg;
    logic [D_W:0]      rem_reg;
    logic [Q_W-1:0]    q_reg;
    logic              qhi_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    logic [Q_W-1:0]    res_reg [rcs_pkg::NUM_JOBS];
    logic [Q_W-1:0]    out_reg [rcs_pkg::NUM_JOBS];

    logic [rcs_pkg::DIM_W-1:0] w_eff, h_eff;
    logic [MOP_W-1:0]  op_a, op_b;
    logic [D_W-1:0]    num_sel, den_sel, spread;
    logic [1:0]        ch;
    logic [D_W:0]      trial;
    logic [Q_W-1:0]    cap, res_val;

    assign pix_chan[0] = chan_l;
    assign pix_chan[1] = chan_a;
    assign pix_chan[2] = chan_b;

    assign w_eff = (width_reg == '0) ? rcs_pkg::DIM_W'(1) : width_reg;
    assign h_eff = (height_reg == '0) ? rcs_pkg::DIM_W'(1) : height_reg;
    assign ch    = rcs_pkg::chan_sel(cmd.job);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rcs_pkg::DEF_WIDTH;
            height_reg <= rcs_pkg::DEF_HEIGHT;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == rcs_pkg::REG_IMAGE_WIDTH)
                width_reg <= cfg_data;
            else if (cfg_index == rcs_pkg::REG_IMAGE_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // accumulators; the count stops once its top bit is set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            scol_reg <= '0;
            srow_reg <= '0;
            for (int k = 0; k < rcs_pkg::NUM_CHAN; k++)
            begin
                sch_reg[k] <= '0;
                ssq_reg[k] <= '0;
            end
        end
        else if (cmd.emit)
        begin
            cnt_reg  <= '0;
            scol_reg <= '0;
            srow_reg <= '0;
            for (int k = 0; k < rcs_pkg::NUM_CHAN; k++)
            begin
                sch_reg[k] <= '0;
                ssq_reg[k] <= '0;
            end
        end
        else if (cmd.acc && !cnt_reg[CNT_W-1])
        begin
            cnt_reg  <= cnt_reg + CNT_W'(1);
            scol_reg <= scol_reg + SCOL_W'(x_coord);
            srow_reg <= srow_reg + SCOL_W'(y_coord);
            for (int k = 0; k < rcs_pkg::NUM_CHAN; k++)
            begin
                sch_reg[k] <= sch_reg[k] + SCH_W'(pix_chan[k]);
                ssq_reg[k] <= ssq_reg[k] + SSQ_W'(pix_chan[k]) * SSQ_W'(pix_chan[k]);
            end
        end
    end

    // multiplier operands
    always_comb
    begin
        op_a = MOP_W'(cnt_reg);
        op_b = MOP_W'(cnt_reg);
        unique case (cmd.job)
            rcs_pkg::JOB_AREA:
            begin
                op_a = MOP_W'(w_eff);
                op_b = MOP_W'(h_eff);
            end
            rcs_pkg::JOB_MEAN_X: op_b = MOP_W'(w_eff);
            rcs_pkg::JOB_MEAN_Y: op_b = MOP_W'(h_eff);
            rcs_pkg::JOB_VAR_L, rcs_pkg::JOB_VAR_A, rcs_pkg::JOB_VAR_B:
            begin
                unique case (cmd.mstep)
                    2'd1: op_b = MOP_W'(ssq_reg[ch]);
                    2'd2:
                    begin
                        op_a = MOP_W'(sch_reg[ch]);
                        op_b = MOP_W'(sch_reg[ch]);
                    end
                    default: op_b = MOP_W'(cnt_reg);
                endcase
            end
            default: op_b = MOP_W'(cnt_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mcnt_reg <= '0;
        else if (cmd.mul_load)
            mcnt_reg <= MCNT_W'(MOP_W);
        else if (cmd.mul_step)
            mcnt_reg <= mcnt_reg - MCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            mcand_reg  <= PRD_W'(op_a);
            mplier_reg <= op_b;
            prod_reg   <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (mplier_reg[0])
                prod_reg <= prod_reg + mcand_reg;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
        if (cmd.capture)
            cap_reg[cmd.mstep] <= prod_reg[D_W-1:0];
    end

    // dividend and divisor per job
    always_comb
    begin
        spread  = (cap_reg[1] < cap_reg[2]) ? '0 : cap_reg[1] - cap_reg[2];
        num_sel = D_W'(cnt_reg) << 16;
        den_sel = cap_reg[0];
        cap     = rcs_pkg::CAP_FRAC;
        unique case (cmd.job)
            rcs_pkg::JOB_AREA:   cap = rcs_pkg::CAP_FULL;
            rcs_pkg::JOB_MEAN_X: num_sel = D_W'(scol_reg) << 16;
            rcs_pkg::JOB_MEAN_Y: num_sel = D_W'(srow_reg) << 16;
            rcs_pkg::JOB_MEAN_L, rcs_pkg::JOB_MEAN_A, rcs_pkg::JOB_MEAN_B:
            begin
                num_sel = D_W'(sch_reg[ch]) << 8;
                den_sel = D_W'(cnt_reg);
            end
            default:
            begin
                num_sel = cap_reg[0] << 16;
                den_sel = cap_reg[0] + spread;
                cap     = rcs_pkg::CAP_FULL;
            end
        endcase
    end

    // restoring division, one quotient bit a cycle; bits above Q_W only flag overflow
    assign trial = {rem_reg[D_W-1:0], num_reg[D_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_load)
            dcnt_reg <= DCNT_W'(D_W);
        else if (cmd.div_step)
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            num_reg <= num_sel;
            den_reg <= den_sel;
            rem_reg <= '0;
            q_reg   <= '0;
            qhi_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            qhi_reg <= qhi_reg | q_reg[Q_W-1];
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[Q_W-2:0], 1'b0};
            end
        end
    end

    assign res_val = (qhi_reg || q_reg > cap) ? cap : q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
            res_reg[cmd.job] <= res_val;
        if (cmd.emit)
            for (int j = 0; j < rcs_pkg::NUM_JOBS; j++)
                out_reg[j] <= res_reg[j];
    end

    assign status.mul_done = (mcnt_reg == '0);
    assign status.div_done = (dcnt_reg == '0);

    assign area_fraction = out_reg[rcs_pkg::JOB_AREA];
    assign mean_x_norm   = out_reg[rcs_pkg::JOB_MEAN_X][F_W-1:0];
    assign mean_y_norm   = out_reg[rcs_pkg::JOB_MEAN_Y][F_W-1:0];
    assign mean_l        = out_reg[rcs_pkg::JOB_MEAN_L][F_W-1:0];
    assign mean_a        = out_reg[rcs_pkg::JOB_MEAN_A][F_W-1:0];
    assign mean_b        = out_reg[rcs_pkg::JOB_MEAN_B][F_W-1:0];
    assign inv_var_l     = out_reg[rcs_pkg::JOB_VAR_L];
    assign inv_var_a     = out_reg[rcs_pkg::JOB_VAR_A];
    assign inv_var_b     = out_reg[rcs_pkg::JOB_VAR_B];

endmodule

// ===== hdl/rcs_controller.sv =====
// Sequencer: accumulation, multiply and divide steps per descriptor field, output hand-off.
`include "region_color_statistics_macros.svh"

module rcs_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    output rcs_pkg::cmd_t     cmd,
    input  rcs_pkg::status_t  status
);
    rcs_pkg::state_t state_reg, state_next;
    rcs_pkg::job_t   job_reg, job_next;
    logic [1:0]      mstep_reg, mstep_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcs_pkg::S_ACC;
            job_reg       <= rcs_pkg::JOB_AREA;
            mstep_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            mstep_reg     <= mstep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        mstep_next = mstep_reg;
        unique case (state_reg)
            rcs_pkg::S_ACC:
                if (in_valid && in_last)
                begin
                    state_next = rcs_pkg::S_MLOAD;
                    job_next   = rcs_pkg::JOB_AREA;
                    mstep_next = 2'd0;
                end
            rcs_pkg::S_MLOAD: state_next = rcs_pkg::S_MRUN;
            rcs_pkg::S_MRUN:
                if (status.mul_done)
                begin
                    if (mstep_reg + 2'd1 < rcs_pkg::mul_count(job_reg))
                    begin
                        mstep_next = mstep_reg + 2'd1;
                        state_next = rcs_pkg::S_MLOAD;
                    end
                    else
                        state_next = rcs_pkg::S_DLOAD;
                end
            rcs_pkg::S_DLOAD: state_next = rcs_pkg::S_DRUN;
            rcs_pkg::S_DRUN:
                if (status.div_done)
                    state_next = rcs_pkg::S_STORE;
            rcs_pkg::S_STORE:
                if (job_reg == rcs_pkg::JOB_VAR_B)
                    state_next = rcs_pkg::S_EMIT;
                else
                begin
                    job_next   = rcs_pkg::job_t'(job_reg + 4'd1);
                    mstep_next = 2'd0;
                    state_next = (rcs_pkg::mul_count(job_next) == 2'd0) ?
                                 rcs_pkg::S_DLOAD : rcs_pkg::S_MLOAD;
                end
            rcs_pkg::S_EMIT:
                if (out_free)
                    state_next = rcs_pkg::S_ACC;
            default: state_next = rcs_pkg::S_ACC;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.job      = job_reg;
        cmd.mstep    = mstep_reg;
        cmd.acc      = (state_reg == rcs_pkg::S_ACC) && in_valid;
        cmd.mul_load = (state_reg == rcs_pkg::S_MLOAD);
        cmd.mul_step = (state_reg == rcs_pkg::S_MRUN) && !status.mul_done;
        cmd.capture  = (state_reg == rcs_pkg::S_MRUN) && status.mul_done;
        cmd.div_load = (state_reg == rcs_pkg::S_DLOAD);
        cmd.div_step = (state_reg == rcs_pkg::S_DRUN) && !status.div_done;
        cmd.store    = (state_reg == rcs_pkg::S_STORE);
        cmd.emit     = (state_reg == rcs_pkg::S_EMIT) && out_free;
        in_ready     = (state_reg == rcs_pkg::S_ACC);
        out_valid_next = cmd.emit ? 1'b1 : (out_valid_reg && !out_ready);
    end

    assign out_valid = out_valid_reg;

    `RCS_ASSERT_NEXT(a_last_starts, clk, rst_n, in_valid && in_ready && in_last, state_reg == rcs_pkg::S_MLOAD && job_reg == rcs_pkg::JOB_AREA, "last pixel did not start the descriptor")
    `RCS_ASSERT_SAME(a_mstep_range, clk, rst_n, state_reg == rcs_pkg::S_MRUN, mstep_reg < rcs_pkg::mul_count(job_reg), "product step beyond job")
    `RCS_ASSERT_NEXT(a_final_emit, clk, rst_n, state_reg == rcs_pkg::S_STORE && job_reg == rcs_pkg::JOB_VAR_B, state_reg == rcs_pkg::S_EMIT, "last field stored without emit")
    `RCS_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid_reg && state_reg == rcs_pkg::S_ACC, "emitted descriptor not presented")

endmodule

// ===== hdl/region_color_statistics.sv =====
// Region colour statistics: top level joining the sequencer and the datapath.
// Pixels are taken one per clock while the block accumulates. The pixel flagged last is
// accumulated too and then the nine descriptor fields are worked out one after another:
// a shift-add multiplier of COUNT_BITS+16 bits (one bit a cycle) forms the products and a
// restoring divider (one quotient bit a cycle over the full dividend width) the quotients.
// During this work no pixel is accepted; the finished descriptor sits in an output register so
// the next region can be accumulated while it waits. Accumulators clear when the descriptor
// is loaded into the output register.
module region_color_statistics #(
    parameter int COORD_BITS = rcs_pkg::DEF_COORD_BITS,
    parameter int COUNT_BITS = rcs_pkg::DEF_COUNT_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    rcs_pixel_if.sink pixel,
    rcs_desc_if.source desc,
    rcs_cfg_if.sink   cfg
);
    rcs_pkg::cmd_t    cmd;
    rcs_pkg::status_t status;

    assign cfg.ready = 1'b1;

    rcs_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_last   (pixel.last_pixel),
        .in_ready  (pixel.ready),
        .out_ready (desc.ready),
        .out_valid (desc.valid),
        .cmd       (cmd),
        .status    (status)
    );

    rcs_datapath #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .x_coord       (pixel.x_coord),
        .y_coord       (pixel.y_coord),
        .chan_l        (pixel.chan_l),
        .chan_a        (pixel.chan_a),
        .chan_b        (pixel.chan_b),
        .area_fraction (desc.area_fraction),
        .mean_x_norm   (desc.mean_x_norm),
        .mean_y_norm   (desc.mean_y_norm),
        .mean_l        (desc.mean_l),
        .mean_a        (desc.mean_a),
        .mean_b        (desc.mean_b),
        .inv_var_l     (desc.inv_var_l),
        .inv_var_a     (desc.inv_var_a),
        .inv_var_b     (desc.inv_var_b)
    );

endmodule

// ===== tb/tb_region_color_statistics.sv =====
// Self-checking testbench for region_color_statistics: random regions against a descriptor predictor.
module tb_region_color_statistics;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF    = 5;
    localparam int          RESET_CYC   = 9;
    localparam int          DESC_CYC    = 1300;      // one descriptor plus margin
    localparam longint      CYCLE_LIMIT = 3000000;
    localparam int          HOLD_CYC    = 4000;
    localparam int          ITEM_TARGET = 700;
    localparam logic [1:0]  REG_SPARE_LO = 2'd2;
    localparam logic [1:0]  REG_SPARE_HI = 2'd3;

    typedef struct {
        bit [16:0] area;
        bit [15:0] mx;
        bit [15:0] my;
        bit [15:0] ml;
        bit [15:0] ma;
        bit [15:0] mb;
        bit [16:0] vl;
        bit [16:0] va;
        bit [16:0] vb;
    } descriptor_t;

    class region_scoreboard;
        bit [12:0]    width_reg;
        bit [12:0]    height_reg;
        bit [24:0]    count;
        bit [35:0]    col_sum;
        bit [35:0]    row_sum;
        bit [31:0]    chan_sum [3];
        bit [39:0]    chan_sq [3];
        descriptor_t  expected_desc [$];
        int           errors;

        function new();
            width_reg  = rcs_pkg::DEF_WIDTH;
            height_reg = rcs_pkg::DEF_HEIGHT;
            errors     = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            count   = 0;
            col_sum = 0;
            row_sum = 0;
            for (int k = 0; k < 3; k++)
            begin
                chan_sum[k] = 0;
                chan_sq[k]  = 0;
            end
        endfunction

        function void write_reg(bit [1:0] idx, bit [12:0] val);
            if (idx == rcs_pkg::REG_IMAGE_WIDTH)
                width_reg = val;
            else if (idx == rcs_pkg::REG_IMAGE_HEIGHT)
                height_reg = val;
        endfunction

        function bit [16:0] quot_cap(bit [127:0] num, bit [127:0] den, bit [16:0] cap);
            bit [127:0] q;
            if (den == 0)
                return cap;
            q = num / den;
            return (q > cap) ? cap : q[16:0];
        endfunction

        function bit [16:0] inv_spread(int k);
            bit [127:0] nn;
            bit [127:0] a;
            bit [127:0] b;
            bit [127:0] spread;
            nn = 128'(count) * 128'(count);
            a  = 128'(count) * 128'(chan_sq[k]);
            b  = 128'(chan_sum[k]) * 128'(chan_sum[k]);
            spread = (a < b) ? 0 : a - b;
            return quot_cap(nn << 16, nn + spread, rcs_pkg::CAP_FULL);
        endfunction

        // Called on every accepted pixel transaction.
        function void note_pixel(bit [11:0] x, bit [11:0] y, bit [7:0] l, bit [7:0] a,
                                 bit [7:0] b, bit last);
            bit [7:0]    ch [3];
            bit [127:0]  w;
            bit [127:0]  h;
            bit [15:0]   means [3];
            descriptor_t d;
            ch[0] = l;
            ch[1] = a;
            ch[2] = b;
            if (count < (25'd1 << rcs_pkg::DEF_COUNT_BITS))
            begin
                count++;
                col_sum += x;
                row_sum += y;
                for (int k = 0; k < 3; k++)
                begin
                    chan_sum[k] += ch[k];
                    chan_sq[k]  += ch[k] * ch[k];
                end
            end
            if (!last)
                return;
            w = (width_reg == 0) ? 1 : width_reg;
            h = (height_reg == 0) ? 1 : height_reg;
            d.area = quot_cap(128'(count) << 16, w * h, rcs_pkg::CAP_FULL);
            d.mx   = 16'(quot_cap(128'(col_sum) << 16, 128'(count) * w, rcs_pkg::CAP_FRAC));
            d.my   = 16'(quot_cap(128'(row_sum) << 16, 128'(count) * h, rcs_pkg::CAP_FRAC));
            for (int k = 0; k < 3; k++)
                means[k] = 16'(quot_cap(128'(chan_sum[k]) << 8, 128'(count),
                                        rcs_pkg::CAP_FRAC));
            d.ml = means[0];
            d.ma = means[1];
            d.mb = means[2];
            d.vl = inv_spread(0);
            d.va = inv_spread(1);
            d.vb = inv_spread(2);
            expected_desc.push_back(d);
            clear_sums();
        endfunction

        task report(string what, int got, int want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_desc(descriptor_t g);
            descriptor_t e;
            if (expected_desc.size() == 0)
            begin
                report("unexpected descriptor, area", g.area, -1);
                return;
            end
            e = expected_desc.pop_front();
            if (g.area != e.area) report("area_fraction", g.area, e.area);
            if (g.mx != e.mx) report("mean_x_norm", g.mx, e.mx);
            if (g.my != e.my) report("mean_y_norm", g.my, e.my);
            if (g.ml != e.ml) report("mean_l", g.ml, e.ml);
            if (g.ma != e.ma) report("mean_a", g.ma, e.ma);
            if (g.mb != e.mb) report("mean_b", g.mb, e.mb);
            if (g.vl != e.vl) report("inv_var_l", g.vl, e.vl);
            if (g.va != e.va) report("inv_var_a", g.va, e.va);
            if (g.vb != e.vb) report("inv_var_b", g.vb, e.vb);
        endtask
    endclass

    logic clk;
    logic rst_n;

    rcs_pixel_if pix_if ();
    rcs_desc_if  desc_if ();
    rcs_cfg_if   cfg_if ();

    region_color_statistics dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pix_if.sink),
        .desc  (desc_if.source),
        .cfg   (cfg_if.sink)
    );

    region_scoreboard sb;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_left;
    longint cycles;
    int     sent_pixels;

    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    initial
    begin
        sb            = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        cycles        = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Accepted transactions on both channels.
    always @(posedge clk)
    begin
        descriptor_t g;
        if (rst_n && pix_if.valid && pix_if.ready)
            sb.note_pixel(pix_if.x_coord, pix_if.y_coord, pix_if.chan_l, pix_if.chan_a,
                          pix_if.chan_b, pix_if.last_pixel);
        if (rst_n && desc_if.valid && desc_if.ready)
        begin
            g.area = desc_if.area_fraction;
            g.mx   = desc_if.mean_x_norm;
            g.my   = desc_if.mean_y_norm;
            g.ml   = desc_if.mean_l;
            g.ma   = desc_if.mean_a;
            g.mb   = desc_if.mean_b;
            g.vl   = desc_if.inv_var_l;
            g.va   = desc_if.inv_var_a;
            g.vb   = desc_if.inv_var_b;
            sb.check_desc(g);
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            desc_if.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else
            desc_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_pixel(bit [11:0] x, bit [11:0] y, bit [7:0] l, bit [7:0] a,
                              bit [7:0] b, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(negedge clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.x_coord    <= x;
        pix_if.y_coord    <= y;
        pix_if.chan_l     <= l;
        pix_if.chan_a     <= a;
        pix_if.chan_b     <= b;
        pix_if.last_pixel <= last;
        do
            @(posedge clk);
        while (!pix_if.ready);
        @(negedge clk);
        sent_pixels++;
    endtask

    task automatic write_cfg(bit [1:0] idx, bit [12:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every descriptor is out and the divider has settled.
    task automatic wait_quiet();
        pix_if.valid <= 1'b0;
        while (sb.expected_desc.size() != 0)
            @(negedge clk);
        repeat (DESC_CYC) @(negedge clk);
    endtask

    task automatic set_dims(bit [12:0] w, bit [12:0] h);
        wait_quiet();
        write_cfg(rcs_pkg::REG_IMAGE_WIDTH, w);
        write_cfg(rcs_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    task automatic send_region(int len, int style, bit [12:0] w, bit [12:0] h);
        bit [7:0]  base [3];
        bit [11:0] x;
        bit [11:0] y;
        bit [7:0]  c [3];
        for (int k = 0; k < 3; k++)
            base[k] = 8'($urandom_range(255));
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(3) == 0 || w == 0 || h == 0)
            begin
                x = 12'($urandom_range(4095));
                y = 12'($urandom_range(4095));
            end
            else
            begin
                x = 12'($urandom_range((w > 4096 ? 4096 : w) - 1));
                y = 12'($urandom_range((h > 4096 ? 4096 : h) - 1));
            end
            for (int k = 0; k < 3; k++)
                case (style)
                    0: c[k] = base[k];
                    1: c[k] = 8'(base[k] + $urandom_range(7));
                    2: c[k] = $urandom_range(1) ? 8'd255 : 8'd0;
                    default: c[k] = 8'($urandom_range(255));
                endcase
            send_pixel(x, y, c[0], c[1], c[2], i == len - 1);
        end
    endtask

    function automatic bit [12:0] pick_dim();
        case ($urandom_range(5))
            0: return 13'd1;
            1: return 13'd4096;
            2: return 13'd0;
            3: return 13'd8191;
            default: return 13'($urandom_range(4096, 1));
        endcase
    endfunction

    initial
    begin
        int        phase;
        bit [12:0] w;
        bit [12:0] h;
        int        len;
        rst_n             = 1'b0;
        pix_if.valid      = 1'b0;
        pix_if.x_coord    = '0;
        pix_if.y_coord    = '0;
        pix_if.chan_l     = '0;
        pix_if.chan_a     = '0;
        pix_if.chan_b     = '0;
        pix_if.last_pixel = 1'b0;
        desc_if.ready     = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        sent_pixels       = 0;
        repeat (RESET_CYC) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, reset dimensions first.
        send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(12'd0, 12'd4095, 8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(12'd4095, 12'd0, 8'd255, 8'd0, 8'd255, 1'b1);
        send_pixel(12'd10, 12'd20, 8'd77, 8'd128, 8'd1, 1'b0);
        send_pixel(12'd11, 12'd21, 8'd77, 8'd128, 8'd1, 1'b0);
        send_pixel(12'd12, 12'd22, 8'd77, 8'd128, 8'd1, 1'b1);
        // Tiny image: area and mean position saturate; spare indexes are ignored.
        set_dims(13'd1, 13'd1);
        write_cfg(REG_SPARE_LO, 13'd5);
        write_cfg(REG_SPARE_HI, 13'd7);
        send_pixel(12'd3, 12'd5, 8'd1, 8'd2, 8'd3, 1'b0);
        send_pixel(12'd4095, 12'd4095, 8'd200, 8'd100, 8'd50, 1'b1);
        // Zero dimensions count as one.
        set_dims(13'd0, 13'd0);
        send_pixel(12'd0, 12'd0, 8'd9, 8'd9, 8'd9, 1'b1);
        send_pixel(12'd1, 12'd0, 8'd8, 8'd9, 8'd10, 1'b1);
        // Oversized dimensions used as given.
        set_dims(13'd8191, 13'd8191);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd0, 8'd128, 1'b0);
        send_pixel(12'd2048, 12'd1, 8'd0, 8'd255, 8'd127, 1'b1);
        set_dims(13'd4096, 13'd4096);
        send_pixel(12'd4095, 12'd0, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(12'd4095, 12'd0, 8'd255, 8'd255, 8'd255, 1'b1);

        phase = 0;
        while (sent_pixels < ITEM_TARGET)
        begin
            w = pick_dim();
            h = pick_dim();
            set_dims(w, h);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 62; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 62; end
                default: begin send_idle_pct = 28; recv_idle_pct = 28; end
            endcase
            // Long receiver hold-off while short regions keep arriving.
            if (phase == 2)
            begin
                hold_left = HOLD_CYC;
                for (int r = 0; r < 4; r++)
                    send_region(1 + $urandom_range(3), 3, w, h);
            end
            for (int r = 0; r < 8; r++)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
                send_region(len, $urandom_range(3), w, h);
            end
            phase++;
        end

        wait_quiet();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
